// ===== rtl/core/u8cc_pkg.sv =====
// Package with the glyph table, matcher and shared types of the UTF-8 charset encoder.
package u8cc_pkg;

    localparam int NumCodes = 255;
    localparam int GlyphMax = 5;
    localparam int WindowBytesDefault = 5;
    localparam logic [15:0] MaxCodesReset = 16'hFFFF;

    typedef struct packed {
        logic [7:0] code;
        logic       is_code;
        logic [15:0] code_count;
        logic       halted;
        logic       end_of_run;
    } res_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       fin;
    } beat_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
        logic [2:0] len;
    } match_t;

    function automatic logic [39:0] hx(input logic [7:0] v);
        logic [3:0] hi;
        logic [3:0] lo;
        logic [7:0] ch;
        logic [7:0] cl;
        hi = v[7:4];
        lo = v[3:0];
        ch = (hi < 4'd10) ? (8'h30 + {4'd0, hi}) : (8'h37 + {4'd0, hi});
        cl = (lo < 4'd10) ? (8'h30 + {4'd0, lo}) : (8'h37 + {4'd0, lo});
        return {8'h30, 8'h78, ch, cl, 8'h00};
    endfunction

    // Glyph bytes packed first byte high, with the length.
    function automatic logic [42:0] glyph(input logic [7:0] c);
        logic [39:0] s;
        logic [2:0]  n;
        s = '0;
        n = 3'd1;
        unique case (c)
            8'd0: s = {8'h20, 32'h0};
            8'd1: begin s = {16'hC380, 24'h0}; n = 3'd2; end
            8'd2: begin s = {16'hC381, 24'h0}; n = 3'd2; end
            8'd3: begin s = {16'hC382, 24'h0}; n = 3'd2; end
            8'd4: begin s = {16'hC387, 24'h0}; n = 3'd2; end
            8'd5: begin s = {16'hC388, 24'h0}; n = 3'd2; end
            8'd6: begin s = {16'hC389, 24'h0}; n = 3'd2; end
            8'd7: begin s = {16'hC38A, 24'h0}; n = 3'd2; end
            8'd8: begin s = {16'hC38B, 24'h0}; n = 3'd2; end
            8'd9: begin s = {16'hC38C, 24'h0}; n = 3'd2; end
            8'd11: begin s = {16'hC38E, 24'h0}; n = 3'd2; end
            8'd12: begin s = {16'hC38F, 24'h0}; n = 3'd2; end
            8'd13: begin s = {16'hC392, 24'h0}; n = 3'd2; end
            8'd14: begin s = {16'hC393, 24'h0}; n = 3'd2; end
            8'd15: begin s = {16'hC394, 24'h0}; n = 3'd2; end
            8'd16: begin s = {16'hC592, 24'h0}; n = 3'd2; end
            8'd17: begin s = {16'hC399, 24'h0}; n = 3'd2; end
            8'd18: begin s = {16'hC39A, 24'h0}; n = 3'd2; end
            8'd19: begin s = {16'hC39B, 24'h0}; n = 3'd2; end
            8'd20: begin s = {16'hC391, 24'h0}; n = 3'd2; end
            8'd21: begin s = {16'hC39F, 24'h0}; n = 3'd2; end
            8'd22: begin s = {16'hC3A0, 24'h0}; n = 3'd2; end
            8'd23: begin s = {16'hC3A1, 24'h0}; n = 3'd2; end
            8'd25: begin s = {16'hC3A7, 24'h0}; n = 3'd2; end
            8'd26: begin s = {16'hC3A8, 24'h0}; n = 3'd2; end
            8'd27: begin s = {16'hC3A9, 24'h0}; n = 3'd2; end
            8'd28: begin s = {16'hC3AA, 24'h0}; n = 3'd2; end
            8'd29: begin s = {16'hC3AB, 24'h0}; n = 3'd2; end
            8'd30: begin s = {16'hC3AC, 24'h0}; n = 3'd2; end
            8'd32: begin s = {16'hC3AE, 24'h0}; n = 3'd2; end
            8'd33: begin s = {16'hC3AF, 24'h0}; n = 3'd2; end
            8'd34: begin s = {16'hC3B2, 24'h0}; n = 3'd2; end
            8'd35: begin s = {16'hC3B3, 24'h0}; n = 3'd2; end
            8'd36: begin s = {16'hC3B4, 24'h0}; n = 3'd2; end
            8'd37: begin s = {16'hC593, 24'h0}; n = 3'd2; end
            8'd38: begin s = {16'hC3B9, 24'h0}; n = 3'd2; end
            8'd39: begin s = {16'hC3BA, 24'h0}; n = 3'd2; end
            8'd40: begin s = {16'hC3BB, 24'h0}; n = 3'd2; end
            8'd41: begin s = {16'hC3B1, 24'h0}; n = 3'd2; end
            8'd42: begin s = {16'hC2BA, 24'h0}; n = 3'd2; end
            8'd43: begin s = {16'hC2AA, 24'h0}; n = 3'd2; end
            8'd44: begin s = {24'hE1B589, 16'h0}; n = 3'd3; end
            8'd45: s = {8'h26, 32'h0};
            8'd46: s = {8'h2B, 32'h0};
            8'd52: begin s = {16'h4C76, 24'h0}; n = 3'd2; end
            8'd53: s = {8'h3D, 32'h0};
            8'd54: s = {8'h3B, 32'h0};
            8'd80: begin s = {24'hE296AF, 16'h0}; n = 3'd3; end
            8'd81: begin s = {16'hC2BF, 24'h0}; n = 3'd2; end
            8'd82: begin s = {16'hC2A1, 24'h0}; n = 3'd2; end
            8'd83: begin s = {16'h504B, 24'h0}; n = 3'd2; end
            8'd84: begin s = {16'h4D4E, 24'h0}; n = 3'd2; end
            8'd85: begin s = {16'h504F, 24'h0}; n = 3'd2; end
            8'd86: begin s = {16'h4B45, 24'h0}; n = 3'd2; end
            8'd87: begin s = {16'hC3A9, 24'h0}; n = 3'd2; end
            8'd90: begin s = {16'hC38D, 24'h0}; n = 3'd2; end
            8'd91: s = {8'h25, 32'h0};
            8'd92: s = {8'h28, 32'h0};
            8'd93: s = {8'h29, 32'h0};
            8'd104: begin s = {16'hC3A2, 24'h0}; n = 3'd2; end
            8'd111: begin s = {16'hC3AD, 24'h0}; n = 3'd2; end
            8'd121: begin s = {24'hE2AC86, 16'h0}; n = 3'd3; end
            8'd122: begin s = {24'hE2AC87, 16'h0}; n = 3'd3; end
            8'd123: begin s = {24'hE2AC85, 16'h0}; n = 3'd3; end
            8'd124: begin s = {24'hE29EA1, 16'h0}; n = 3'd3; end
            8'd125, 8'd126, 8'd127, 8'd128, 8'd129, 8'd130, 8'd131: s = {8'h2A, 32'h0};
            8'd132: begin s = {24'hE1B589, 16'h0}; n = 3'd3; end
            8'd133: s = {8'h3C, 32'h0};
            8'd134: s = {8'h3E, 32'h0};
            8'd160: begin s = 40'hCAB3E1B589; n = 3'd5; end
            8'd161, 8'd162, 8'd163, 8'd164, 8'd165, 8'd166, 8'd167, 8'd168, 8'd169,
            8'd170: s = {8'h30 + (c - 8'd161), 32'h0};
            8'd171: s = {8'h21, 32'h0};
            8'd172: s = {8'h3F, 32'h0};
            8'd173: s = {8'h2E, 32'h0};
            8'd174: s = {8'h2D, 32'h0};
            8'd175: begin s = {24'hE383BB, 16'h0}; n = 3'd3; end
            8'd176: begin s = {24'hE280A6, 16'h0}; n = 3'd3; end
            8'd177: begin s = {24'hE2809C, 16'h0}; n = 3'd3; end
            8'd178: begin s = {24'hE2809D, 16'h0}; n = 3'd3; end
            8'd179: begin s = {24'hE28098, 16'h0}; n = 3'd3; end
            8'd180: begin s = {24'hE28099, 16'h0}; n = 3'd3; end
            8'd181: begin s = {24'hE29982, 16'h0}; n = 3'd3; end
            8'd182: begin s = {24'hE29980, 16'h0}; n = 3'd3; end
            8'd183: s = {8'h24, 32'h0};
            8'd184: s = {8'h2C, 32'h0};
            8'd185: begin s = {16'hC397, 24'h0}; n = 3'd2; end
            8'd186: s = {8'h2F, 32'h0};
            8'd239: begin s = {24'hE296B6, 16'h0}; n = 3'd3; end
            8'd240: s = {8'h3A, 32'h0};
            8'd241: begin s = {16'hC384, 24'h0}; n = 3'd2; end
            8'd242: begin s = {16'hC396, 24'h0}; n = 3'd2; end
            8'd243: begin s = {16'hC39C, 24'h0}; n = 3'd2; end
            8'd244: begin s = {16'hC3A4, 24'h0}; n = 3'd2; end
            8'd245: begin s = {16'hC3B6, 24'h0}; n = 3'd2; end
            8'd246: begin s = {16'hC3BC, 24'h0}; n = 3'd2; end
            default: begin
                if (c >= 8'd187 && c <= 8'd212) begin
                    s = {8'h41 + (c - 8'd187), 32'h0};
                end else if (c >= 8'd213 && c <= 8'd238) begin
                    s = {8'h61 + (c - 8'd213), 32'h0};
                end else begin
                    s = hx(c);
                    n = 3'd4;
                end
            end
        endcase
        return {n, s};
    endfunction

    // First table entry that is a prefix of the window head.
    function automatic match_t find_match(input logic [39:0] head, input logic [3:0] fill);
        match_t     m;
        logic [42:0] g;
        logic [39:0] mask;
        m = '0;
        for (int c = NumCodes - 1; c >= 0; c--) begin
            g = glyph(8'(c));
            mask = ~(40'hFF_FFFF_FFFF >> (8 * int'(g[42:40])));
            if ({1'b0, g[42:40]} <= fill && ((head & mask) == g[39:0])) begin
                m.hit = 1'b1;
                m.code = 8'(c);
                m.len = g[42:40];
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/u8cc_front.sv =====
// Input side: accepts byte beats into a two-entry queue.
module u8cc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  u8cc_pkg::beat_t      in_beat,
    output logic                 q_valid,
    input  logic                 q_pop,
    output u8cc_pkg::beat_t      q_beat
);

    u8cc_pkg::beat_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_beat = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_beat;
    end

endmodule

// ===== rtl/core/u8cc_back.sv =====
// Output side: window, matcher, flush sequencing and result register.
module u8cc_back #(
    parameter int WindowBytes = u8cc_pkg::WindowBytesDefault
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          max_codes,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  u8cc_pkg::beat_t      q_beat,
    output logic                 res_valid,
    input  logic                 res_ready,
    output u8cc_pkg::res_t       res
);

    localparam int FillW = $clog2(WindowBytes + 1);

    logic [7:0] win_reg [WindowBytes];
    logic [7:0] win_next [WindowBytes];
    logic [FillW-1:0] fill_reg, fill_next;
    logic stop_reg, stop_next;
    logic [15:0] emit_reg, emit_next;
    logic flush_reg, flush_next;
    logic       ov_reg;
    u8cc_pkg::res_t rs_reg;
    logic [39:0] head;
    u8cc_pkg::match_t m;
    logic can_match, room, out_free;
    u8cc_pkg::res_t rnext;
    logic rload;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            head[39 - 8 * i -: 8] = (i < WindowBytes) ? win_reg[i] : 8'h00;
        end
    end

    assign m = u8cc_pkg::find_match(head, 4'(fill_reg));
    assign can_match = !stop_reg && (emit_reg < max_codes);
    assign out_free = !ov_reg || res_ready;
    assign res_valid = ov_reg;
    assign res = rs_reg;

    always_comb begin
        win_next = win_reg;
        fill_next = fill_reg;
        stop_next = stop_reg;
        emit_next = emit_reg;
        flush_next = flush_reg;
        q_pop = 1'b0;
        rload = 1'b0;
        rnext = rs_reg;
        room = (fill_reg < FillW'(WindowBytes));
        if (can_match && (fill_reg == FillW'(WindowBytes) || (flush_reg && fill_reg != '0)))
        begin
            if (!m.hit) begin
                stop_next = 1'b1;
            end else if (out_free) begin
                rload = 1'b1;
                emit_next = emit_reg + 16'd1;
                rnext = '{code: m.code, is_code: 1'b1, code_count: emit_reg + 16'd1,
                          halted: 1'b0, end_of_run: 1'b0};
                for (int i = 0; i < WindowBytes; i++) begin
                    win_next[i] = (i + int'(m.len) < WindowBytes) ?
                                  win_reg[i + int'(m.len)] : 8'h00;
                end
                fill_next = fill_reg - FillW'(m.len);
            end
        end else if (flush_reg) begin
            if (out_free) begin
                rload = 1'b1;
                rnext = '{code: 8'h00, is_code: 1'b0, code_count: emit_reg,
                          halted: stop_reg, end_of_run: 1'b1};
                for (int i = 0; i < WindowBytes; i++) win_next[i] = 8'h00;
                fill_next = '0;
                stop_next = 1'b0;
                emit_next = 16'd0;
                flush_next = 1'b0;
            end
        end else if (q_valid) begin
            q_pop = 1'b1;
            if (can_match && room) begin
                win_next[fill_reg[FillW-1:0]] = q_beat.in_byte;
                fill_next = fill_reg + FillW'(1);
            end
            flush_next = q_beat.fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WindowBytes; i++) win_reg[i] <= 8'h00;
            fill_reg <= '0;
            stop_reg <= 1'b0;
            emit_reg <= 16'd0;
            flush_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            win_reg <= win_next;
            fill_reg <= fill_next;
            stop_reg <= stop_next;
            emit_reg <= emit_next;
            flush_reg <= flush_next;
            if (rload) ov_reg <= 1'b1;
            else if (res_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rload) rs_reg <= rnext;
    end

endmodule

// ===== rtl/core/utf8_to_charset_code_encoder_unit.sv =====
// Top level of the UTF-8 to single-byte charset encoder.
//   channel | direction | ports
//   s_      | in        | s_valid s_ready s_byte_in s_final_byte
//   m_      | out       | m_valid m_ready m_code m_is_code m_code_count m_halted m_end_of_run
//   cfg     | in        | cfg_we cfg_wdata (max_codes)
// The single shared matcher over the window sets the rate: one code or one byte per cycle
// while the result register can take a beat; a summary beat goes out on that path too.
// Reset is synchronous; max_codes returns to 65535 and the window empties.
// A two-beat queue parts input from the matcher, and the result register parts it from output.
module utf8_to_charset_code_encoder_unit #(
    parameter int WindowBytes = u8cc_pkg::WindowBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_code,
    output logic        m_is_code,
    output logic [15:0] m_code_count,
    output logic        m_halted,
    output logic        m_end_of_run
);

    logic [15:0] max_reg;
    logic q_valid, q_pop;
    u8cc_pkg::beat_t s_beat;
    u8cc_pkg::beat_t q_beat;
    u8cc_pkg::res_t res;

    assign s_beat = '{in_byte: s_byte_in, fin: s_final_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= u8cc_pkg::MaxCodesReset;
        end else if (cfg_we) begin
            max_reg <= cfg_wdata;
        end
    end

    u8cc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_beat(s_beat),
        .q_valid(q_valid), .q_pop(q_pop), .q_beat(q_beat)
    );

    u8cc_back #(.WindowBytes(WindowBytes)) u_back (
        .aclk(aclk), .aresetn(aresetn), .max_codes(max_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_beat(q_beat),
        .res_valid(m_valid), .res_ready(m_ready), .res(res)
    );

    assign m_code = res.code;
    assign m_is_code = res.is_code;
    assign m_code_count = res.code_count;
    assign m_halted = res.halted;
    assign m_end_of_run = res.end_of_run;

`ifndef SYNTHESIS
    a_summary_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_run |-> !m_is_code && m_code == 8'h00)
        else $error("summary beat carries a code");
    a_code_not_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_code |-> !m_halted && m_code_count != 16'd0)
        else $error("code beat with halt or zero count");
    a_code_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_code |-> m_code != 8'hFF)
        else $error("code out of range");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the UTF-8 to single-byte charset encoder: directed and random strings checked.
`timescale 1ns / 1ps

module tb_top;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in = '0;
    logic        s_final_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_code;
    logic        m_is_code;
    logic [15:0] m_code_count;
    logic        m_halted;
    logic        m_end_of_run;

    utf8_to_charset_code_encoder_unit u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_byte_in(s_byte_in),
        .s_final_byte(s_final_byte), .m_valid(m_valid), .m_ready(m_ready),
        .m_code(m_code), .m_is_code(m_is_code), .m_code_count(m_code_count),
        .m_halted(m_halted), .m_end_of_run(m_end_of_run)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [7:0]  glyph_bytes [u8cc_pkg::NumCodes][5];
    int          glyph_size [u8cc_pkg::NumCodes];
    logic [7:0]  win [5];
    int          win_fill;
    bit          halt_seen;
    logic [15:0] code_total;
    logic [15:0] code_limit;
    u8cc_pkg::res_t expected_q [$];
    int          fail_count = 0;
    bit          s_took = 1'b0;
    int          burst_left = 0;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
    endfunction

    task automatic put_glyph(input int c, input int n, input logic [39:0] v);
        for (int i = 0; i < n; i++) glyph_bytes[c][i] = v[8 * (n - 1 - i) +: 8];
        glyph_size[c] = n;
    endtask

    task automatic build_glyphs();
        logic [15:0] two [256];
        for (int c = 0; c < u8cc_pkg::NumCodes; c++)
            put_glyph(c, 4, {16'h3078, hex_char(c[7:4]), hex_char(c[3:0])});
        for (int c = 0; c < 256; c++) two[c] = '0;
        two[1] = 16'hC380; two[2] = 16'hC381; two[3] = 16'hC382; two[4] = 16'hC387;
        two[5] = 16'hC388; two[6] = 16'hC389; two[7] = 16'hC38A; two[8] = 16'hC38B;
        two[9] = 16'hC38C; two[11] = 16'hC38E; two[12] = 16'hC38F; two[13] = 16'hC392;
        two[14] = 16'hC393; two[15] = 16'hC394; two[16] = 16'hC592; two[17] = 16'hC399;
        two[18] = 16'hC39A; two[19] = 16'hC39B; two[20] = 16'hC391; two[21] = 16'hC39F;
        two[22] = 16'hC3A0; two[23] = 16'hC3A1; two[25] = 16'hC3A7; two[26] = 16'hC3A8;
        two[27] = 16'hC3A9; two[28] = 16'hC3AA; two[29] = 16'hC3AB; two[30] = 16'hC3AC;
        two[32] = 16'hC3AE; two[33] = 16'hC3AF; two[34] = 16'hC3B2; two[35] = 16'hC3B3;
        two[36] = 16'hC3B4; two[37] = 16'hC593; two[38] = 16'hC3B9; two[39] = 16'hC3BA;
        two[40] = 16'hC3BB; two[41] = 16'hC3B1; two[42] = 16'hC2BA; two[43] = 16'hC2AA;
        two[52] = 16'h4C76; two[81] = 16'hC2BF; two[82] = 16'hC2A1; two[83] = 16'h504B;
        two[84] = 16'h4D4E; two[85] = 16'h504F; two[86] = 16'h4B45; two[87] = 16'hC3A9;
        two[90] = 16'hC38D; two[104] = 16'hC3A2; two[111] = 16'hC3AD; two[185] = 16'hC397;
        two[241] = 16'hC384; two[242] = 16'hC396; two[243] = 16'hC39C; two[244] = 16'hC3A4;
        two[245] = 16'hC3B6; two[246] = 16'hC3BC;
        for (int c = 0; c < u8cc_pkg::NumCodes; c++)
            if (two[c] != 0) put_glyph(c, 2, 40'(two[c]));
        put_glyph(0, 1, 40'h20); put_glyph(45, 1, 40'h26); put_glyph(46, 1, 40'h2B);
        put_glyph(53, 1, 40'h3D); put_glyph(54, 1, 40'h3B); put_glyph(91, 1, 40'h25);
        put_glyph(92, 1, 40'h28); put_glyph(93, 1, 40'h29); put_glyph(133, 1, 40'h3C);
        put_glyph(134, 1, 40'h3E); put_glyph(171, 1, 40'h21); put_glyph(172, 1, 40'h3F);
        put_glyph(173, 1, 40'h2E); put_glyph(174, 1, 40'h2D); put_glyph(183, 1, 40'h24);
        put_glyph(184, 1, 40'h2C); put_glyph(186, 1, 40'h2F); put_glyph(240, 1, 40'h3A);
        for (int c = 125; c <= 131; c++) put_glyph(c, 1, 40'h2A);
        for (int c = 161; c <= 170; c++) put_glyph(c, 1, 40'(8'h30 + c - 161));
        for (int c = 187; c <= 212; c++) put_glyph(c, 1, 40'(8'h41 + c - 187));
        for (int c = 213; c <= 238; c++) put_glyph(c, 1, 40'(8'h61 + c - 213));
        put_glyph(44, 3, 40'hE1B589); put_glyph(132, 3, 40'hE1B589);
        put_glyph(80, 3, 40'hE296AF); put_glyph(121, 3, 40'hE2AC86);
        put_glyph(122, 3, 40'hE2AC87); put_glyph(123, 3, 40'hE2AC85);
        put_glyph(124, 3, 40'hE29EA1); put_glyph(175, 3, 40'hE383BB);
        put_glyph(176, 3, 40'hE280A6); put_glyph(177, 3, 40'hE2809C);
        put_glyph(178, 3, 40'hE2809D); put_glyph(179, 3, 40'hE28098);
        put_glyph(180, 3, 40'hE28099); put_glyph(181, 3, 40'hE29982);
        put_glyph(182, 3, 40'hE29980); put_glyph(239, 3, 40'hE296B6);
        put_glyph(160, 5, 40'hCAB3E1B589);
    endtask

    task automatic clear_string();
        for (int i = 0; i < 5; i++) win[i] = '0;
        win_fill = 0;
        halt_seen = 1'b0;
        code_total = '0;
    endtask

    task automatic match_head();
        bit same;
        for (int c = 0; c < u8cc_pkg::NumCodes; c++) begin
            if (glyph_size[c] > win_fill) continue;
            same = 1'b1;
            for (int i = 0; i < glyph_size[c]; i++)
                if (win[i] != glyph_bytes[c][i]) same = 1'b0;
            if (!same) continue;
            code_total++;
            expected_q.push_back('{code: 8'(c), is_code: 1'b1, code_count: code_total,
                                   halted: 1'b0, end_of_run: 1'b0});
            for (int i = 0; i < 5; i++)
                win[i] = (i + glyph_size[c] < win_fill) ? win[i + glyph_size[c]] : 8'h00;
            win_fill -= glyph_size[c];
            return;
        end
        halt_seen = 1'b1;
    endtask

    task automatic predict_codes(input logic [7:0] b, input logic fin);
        if (!halt_seen && code_total < code_limit && win_fill < 5) begin
            win[win_fill] = b;
            win_fill++;
            if (win_fill >= 5) match_head();
        end
        if (fin) begin
            while (win_fill > 0 && !halt_seen && code_total < code_limit) match_head();
            expected_q.push_back('{code: 8'h00, is_code: 1'b0, code_count: code_total,
                                   halted: halt_seen, end_of_run: 1'b1});
            clear_string();
        end
    endtask

    always @(posedge aclk) s_took <= s_valid && s_ready;

    // Receiver stall pattern: long open stretches, random stalls, and stall bursts.
    always @(negedge aclk) begin
        int phase;
        phase = ($time / 2000) % 4;
        if (phase == 0) m_ready = 1'b1;
        else if (phase == 1) m_ready = ($urandom_range(0, 1) == 1);
        else if (phase == 2) m_ready = ($urandom_range(0, 7) == 0);
        else m_ready = (($time / 40) % 3 != 0);
    end

    always @(posedge aclk) begin
        u8cc_pkg::res_t got;
        u8cc_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{code: m_code, is_code: m_is_code, code_count: m_code_count,
                    halted: m_halted, end_of_run: m_end_of_run};
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("Unexpected result beat: %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                s_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
        burst_left--;
        s_byte_in = b;
        s_final_byte = fin;
        s_valid = 1'b1;
        do @(negedge aclk); while (!s_took);
        predict_codes(b, fin);
    endtask

    task automatic send_string(input logic [7:0] bytes [$]);
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
        s_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        wait_idle();
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we = 1'b0;
        code_limit = v;
    endtask

    task automatic test_glyph_extremes();
        send_string('{8'h00});
        send_string('{8'hFF});
        send_string('{8'h30, 8'h78, 8'h46, 8'h45});
        send_string('{8'hCA, 8'hB3, 8'hE1, 8'hB5, 8'h89});
        send_string('{8'hE3, 8'h83, 8'hBB, 8'h4C, 8'h76});
        send_string('{8'h48, 8'h65, 8'h6C, 8'h6C, 8'h6F, 8'h20, 8'h57, 8'h6F, 8'h72, 8'h6C});
    endtask

    task automatic test_first_match_order();
        send_string('{8'h30, 8'h78, 8'h30, 8'h41, 8'h30});
        send_string('{8'hC3, 8'hA9, 8'hE1, 8'hB5, 8'h89, 8'h2A});
    endtask

    task automatic test_halt();
        send_string('{8'h20, 8'h7E, 8'h41, 8'h42});
        send_string('{8'h41, 8'hC3, 8'h00, 8'h42, 8'h43, 8'h44, 8'h45});
    endtask

    task automatic test_code_limit();
        write_limit(16'd1);
        send_string('{8'h41, 8'h42, 8'h43});
        write_limit(16'd0);
        send_string('{8'h41, 8'h42});
        write_limit(16'd3);
        send_string('{8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47});
        write_limit(16'hFFFF);
    endtask

    task automatic test_random(input int n_bytes);
        logic [7:0] bytes [$];
        int sent;
        int c;
        int target;
        sent = 0;
        while (sent < n_bytes) begin
            bytes.delete();
            target = $urandom_range(1, 14);
            while (bytes.size() < target) begin
                c = $urandom_range(0, u8cc_pkg::NumCodes - 1);
                for (int i = 0; i < glyph_size[c]; i++) bytes.push_back(glyph_bytes[c][i]);
            end
            if ($urandom_range(0, 3) == 0)
                bytes.insert($urandom_range(0, bytes.size()), 8'($urandom_range(0, 255)));
            send_string(bytes);
            sent += bytes.size();
        end
    endtask

    initial begin
        build_glyphs();
        clear_string();
        code_limit = u8cc_pkg::MaxCodesReset;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_glyph_extremes();
        test_first_match_order();
        test_halt();
        test_code_limit();
        test_random(70);
        write_limit(16'($urandom_range(1, 4)));
        test_random(60);
        write_limit(16'd0);
        test_random(20);
        write_limit(16'($urandom_range(0, 65535)));
        test_random(50);
        write_limit(16'hFFFF);
        test_random(50);
        wait_idle();
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
